// ----- design/counting_semaphore_table_core_assert.svh -----
// ----------------------------------------------------------------------------
// counting_semaphore_table_core_assert.svh
// Assertion helper macros for the semaphore table core.
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_TABLE_CORE_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define CSEM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/csem_pkg.sv -----
// ----------------------------------------------------------------------------
// csem_pkg
// Shared codes, defaults and control types of the semaphore table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csem_pkg;

  localparam int NUM_SEMS_DEF    = 16;
  localparam int MAX_WAITERS_DEF = 8;

  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_WAIT    = 3'd1;
  localparam logic [2:0] CMD_SIGNAL  = 3'd2;
  localparam logic [2:0] CMD_DESTROY = 3'd3;
  localparam logic [2:0] CMD_RELEASE = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_BUSY      = 3'd2;
  localparam logic [2:0] ST_NOT_OWNER = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic signed [15:0] COUNT_MAX = 16'sd32767;

  typedef struct packed {
    logic latch;
    logic decode;
    logic entry_rd;
    logic eval;
    logic wake_cap;
    logic rel_rd;
    logic rel_eval;
  } ctl_t;

  typedef struct packed {
    logic rel;
    logic short_done;
    logic wake;
    logic rel_last;
  } sts_t;

endpackage

// ----- design/csem_ram.sv -----
// ----------------------------------------------------------------------------
// csem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/csem_ctrl.sv -----
// ----------------------------------------------------------------------------
// csem_ctrl
// Command sequencer: decode, entry read-modify-write, wake read, release walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csem_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  csem_pkg::sts_t sts,
  output csem_pkg::ctl_t ctl,
  output logic          busy,
  output logic          out_valid
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_EV     = 3'd3;
  localparam logic [2:0] S_WK     = 3'd4;
  localparam logic [2:0] S_REL_RD = 3'd5;
  localparam logic [2:0] S_REL_EV = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.decode = 1'b1;
        if (sts.rel) state_nxt = S_REL_RD;
        else if (sts.short_done) state_nxt = S_DONE;
        else state_nxt = S_RD;
      end
      S_RD: begin
        ctl.entry_rd = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        ctl.eval = 1'b1;
        state_nxt = sts.wake ? S_WK : S_DONE;
      end
      S_WK: begin
        ctl.wake_cap = 1'b1;
        state_nxt = S_DONE;
      end
      S_REL_RD: begin
        ctl.rel_rd = 1'b1;
        state_nxt = S_REL_EV;
      end
      S_REL_EV: begin
        ctl.rel_eval = 1'b1;
        state_nxt = sts.rel_last ? S_DONE : S_REL_RD;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// ----- design/csem_datapath.sv -----
// ----------------------------------------------------------------------------
// csem_datapath
// Entry flags, entry and waiter RAMs, command evaluation and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csem_datapath #(
  parameter int NUM_SEMS    = csem_pkg::NUM_SEMS_DEF,
  parameter int MAX_WAITERS = csem_pkg::MAX_WAITERS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  csem_pkg::ctl_t ctl,
  output csem_pkg::sts_t sts,
  input  logic [2:0]     in_command,
  input  logic [7:0]     in_sem_index,
  input  logic [14:0]    in_init_value,
  input  logic [15:0]    in_caller_id,
  output logic [2:0]     out_status,
  output logic           out_caller_blocks,
  output logic           out_woken_valid,
  output logic [15:0]    out_woken_id,
  output logic [8:0]     out_freed_count
);

  localparam int IW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int HW  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int FW  = $clog2(MAX_WAITERS + 1);
  localparam int PW  = HW + 1;
  localparam int EW  = 32 + HW + FW;
  localparam int WD  = NUM_SEMS * MAX_WAITERS;
  localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

  logic [2:0]          cmd_r;
  logic [7:0]          sem_r;
  logic [14:0]         ival_r;
  logic [15:0]         caller_r;
  logic [NUM_SEMS-1:0] in_use_r;
  logic [IW-1:0]       idx_r;
  logic [8:0]          freed_r;
  logic [2:0]          status_r;
  logic                blocks_r;
  logic                wvalid_r;
  logic [15:0]         wid_r;

  logic            idx_ok, cur_use;
  logic [IW-1:0]   sidx;
  logic [EW-1:0]   e_rd, e_wdata, ev_entry, init_entry;
  logic            e_we, e_re;
  logic [IW-1:0]   e_raddr;
  logic [15:0]     e_owner;
  logic signed [15:0] e_count, next_cnt, inc_cnt;
  logic [HW-1:0]   e_head, head_inc;
  logic [FW-1:0]   e_fill;
  logic [PW-1:0]   pos_sum, tail;
  logic [WAW-1:0]  base, ww_addr, wr_addr;
  logic [15:0]     w_rd;
  logic            ww_en, w_re;

  logic [2:0] dec_status, ev_status;
  logic       dec_short, init_ok;
  logic       ev_blocks, ev_wake, ev_we, clear_use, rel_hit;

  assign idx_ok  = ({1'b0, sem_r} < 9'(NUM_SEMS));
  assign sidx    = sem_r[IW-1:0];
  assign cur_use = idx_ok && in_use_r[sidx];

  assign e_owner = e_rd[EW-1 -: 16];
  assign e_count = $signed(e_rd[EW-17 -: 16]);
  assign e_head  = e_rd[FW +: HW];
  assign e_fill  = e_rd[FW-1:0];

  assign init_entry = {caller_r, 1'b0, ival_r, {HW{1'b0}}, {FW{1'b0}}};

  always_comb begin
    dec_status = csem_pkg::ST_OK;
    dec_short  = 1'b1;
    init_ok    = 1'b0;
    if (cmd_r == csem_pkg::CMD_RELEASE) begin
      dec_short = 1'b0;
    end else if (cmd_r > csem_pkg::CMD_RELEASE || !idx_ok) begin
      dec_status = csem_pkg::ST_INVALID;
    end else if (cmd_r == csem_pkg::CMD_INIT) begin
      if (cur_use) dec_status = csem_pkg::ST_BUSY;
      else init_ok = 1'b1;
    end else if (!cur_use) begin
      dec_status = csem_pkg::ST_INVALID;
    end else begin
      dec_short = 1'b0;
    end
  end

  assign next_cnt = e_count - 16'sd1;
  assign inc_cnt  = (e_count < csem_pkg::COUNT_MAX) ? e_count + 16'sd1 : e_count;
  assign head_inc = (e_head == HW'(MAX_WAITERS - 1)) ? '0 : e_head + HW'(1);
  assign pos_sum  = PW'(e_head) + PW'(e_fill);
  assign tail     = (pos_sum >= PW'(MAX_WAITERS)) ? pos_sum - PW'(MAX_WAITERS) : pos_sum;
  assign base     = WAW'(sidx) * WAW'(MAX_WAITERS);
  assign ww_addr  = base + WAW'(tail);
  assign wr_addr  = base + WAW'(e_head);

  always_comb begin
    ev_status = csem_pkg::ST_OK;
    ev_blocks = 1'b0;
    ev_wake   = 1'b0;
    ev_we     = 1'b0;
    ww_en     = 1'b0;
    clear_use = 1'b0;
    ev_entry  = e_rd;
    case (cmd_r)
      csem_pkg::CMD_WAIT: begin
        if (next_cnt < 16'sd0) begin
          if (e_fill == FW'(MAX_WAITERS)) begin
            ev_status = csem_pkg::ST_FULL;
          end else begin
            ww_en     = 1'b1;
            ev_blocks = 1'b1;
            ev_we     = 1'b1;
            ev_entry  = {e_owner, next_cnt, e_head, e_fill + FW'(1)};
          end
        end else begin
          ev_we    = 1'b1;
          ev_entry = {e_owner, next_cnt, e_head, e_fill};
        end
      end
      csem_pkg::CMD_SIGNAL: begin
        ev_we = 1'b1;
        if (e_fill != '0) begin
          ev_wake  = 1'b1;
          ev_entry = {e_owner, inc_cnt, head_inc, e_fill - FW'(1)};
        end else begin
          ev_entry = {e_owner, inc_cnt, e_head, e_fill};
        end
      end
      csem_pkg::CMD_DESTROY: begin
        if (e_owner != caller_r) ev_status = csem_pkg::ST_NOT_OWNER;
        else if (e_fill != '0) ev_status = csem_pkg::ST_BUSY;
        else clear_use = 1'b1;
      end
      default: ;
    endcase
  end

  assign rel_hit = in_use_r[idx_r] && (e_owner == caller_r) && (e_fill == '0);

  assign e_we    = (ctl.decode && init_ok) || (ctl.eval && ev_we);
  assign e_wdata = ctl.decode ? init_entry : ev_entry;
  assign e_re    = ctl.entry_rd || ctl.rel_rd;
  assign e_raddr = ctl.rel_rd ? idx_r : sidx;
  assign w_re    = ctl.eval && ev_wake;

  csem_ram #(.WIDTH(EW), .DEPTH(NUM_SEMS)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (sidx),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rd)
  );

  csem_ram #(.WIDTH(16), .DEPTH(WD)) u_waiter_ram (
    .clk   (clk),
    .we    (ctl.eval && ww_en),
    .waddr (ww_addr),
    .wdata (caller_r),
    .re    (w_re),
    .raddr (wr_addr),
    .rdata (w_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else if (ctl.decode && init_ok) begin
      in_use_r[sidx] <= 1'b1;
    end else if (ctl.eval && clear_use) begin
      in_use_r[sidx] <= 1'b0;
    end else if (ctl.rel_eval && rel_hit) begin
      in_use_r[idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r    <= in_command;
      sem_r    <= in_sem_index;
      ival_r   <= in_init_value;
      caller_r <= in_caller_id;
      status_r <= csem_pkg::ST_OK;
      blocks_r <= 1'b0;
      wvalid_r <= 1'b0;
      wid_r    <= '0;
      freed_r  <= '0;
      idx_r    <= '0;
    end
    if (ctl.decode) begin
      status_r <= dec_status;
    end
    if (ctl.eval) begin
      status_r <= ev_status;
      blocks_r <= ev_blocks;
      wvalid_r <= ev_wake;
    end
    if (ctl.wake_cap) begin
      wid_r <= w_rd;
    end
    if (ctl.rel_eval) begin
      if (rel_hit) freed_r <= freed_r + 9'd1;
      idx_r <= idx_r + IW'(1);
    end
  end

  assign sts.rel        = (cmd_r == csem_pkg::CMD_RELEASE);
  assign sts.short_done = dec_short;
  assign sts.wake       = ev_wake;
  assign sts.rel_last   = (idx_r == IW'(NUM_SEMS - 1));

  assign out_status        = status_r;
  assign out_caller_blocks = blocks_r;
  assign out_woken_valid   = wvalid_r;
  assign out_woken_id      = wid_r;
  assign out_freed_count   = freed_r;

endmodule

// ----- design/counting_semaphore_table_core.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_table_core
// Table of counting semaphores with owner, count and FIFO of blocked tasks.
//
// A command transfers on a rising edge with start high and busy low; busy
// stays high until the result has been shown. Each command yields one
// result, on the out_ ports for one cycle while out_valid is high; the
// receiver cannot stall, so it must take it in that cycle.
// States from accept to the out_valid state (DONE):
//   invalid, busy-on-init and init: DECODE, DONE
//   wait, destroy, signal without waiter: DECODE, RD, EV, DONE
//   signal that wakes a waiter: adds WK (extra waiter RAM read)
//   release: DECODE, REL_RD/REL_EV per entry (one RAM read, check), DONE
// A new command may start the cycle after out_valid.
// Reset frees all entries; the RAMs need no clearing, as
// an entry's contents are written by init before any use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "counting_semaphore_table_core_assert.svh"

module counting_semaphore_table_core #(
  parameter int NUM_SEMS    = csem_pkg::NUM_SEMS_DEF,
  parameter int MAX_WAITERS = csem_pkg::MAX_WAITERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_sem_index,
  input  logic [14:0] in_init_value,
  input  logic [15:0] in_caller_id,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_caller_blocks,
  output logic        out_woken_valid,
  output logic [15:0] out_woken_id,
  output logic [8:0]  out_freed_count
);

  csem_pkg::ctl_t ctl;
  csem_pkg::sts_t sts;

  csem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  csem_datapath #(.NUM_SEMS(NUM_SEMS), .MAX_WAITERS(MAX_WAITERS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_command        (in_command),
    .in_sem_index      (in_sem_index),
    .in_init_value     (in_init_value),
    .in_caller_id      (in_caller_id),
    .out_status        (out_status),
    .out_caller_blocks (out_caller_blocks),
    .out_woken_valid   (out_woken_valid),
    .out_woken_id      (out_woken_id),
    .out_freed_count   (out_freed_count)
  );

  `CSEM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")
  `CSEM_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid && !busy, "result strobe not one cycle")
  `CSEM_ASSERT_IMPL(a_wake_ok, out_valid && out_woken_valid, out_status == csem_pkg::ST_OK && !out_caller_blocks, "wake with bad status")
  `CSEM_ASSERT_IMPL(a_freed_ok, out_valid && out_freed_count != 9'd0, out_status == csem_pkg::ST_OK && !out_woken_valid, "freed count on non-release")

endmodule
